### hdl/gpha_pkg.sv
// shared types, constants and the chromosome offset table for the genome pair heatmap
// accumulator; no dependencies
package gpha_pkg;

    localparam int DEF_MAX_WIDTH   = 256;
    localparam int DEF_CHROM_COUNT = 24;

    localparam int CHROM_W = 5;
    localparam int POS_W   = 28;
    localparam int IDX_W   = 16;
    localparam int PIX_W   = 8;
    localparam int COORD_W = 32;
    localparam int OFS_W   = 6;
    localparam int CFG_W   = 9;
    localparam int STEP_W  = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [63:0] GENOME_LEN = 64'd3036303846;
    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_STEP  = 1'b1;

    localparam logic [CFG_W-1:0]  IMAGE_WIDTH_RST = 9'd200;
    localparam logic [STEP_W-1:0] COLOR_STEP_RST  = 8'd15;

    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BIN,
        ST_INDEX,
        ST_READ,
        ST_WRITE
    } gpha_state_t;

    // cumulative chromosome start positions, zero past the fixed entries
    function automatic logic [COORD_W-1:0] chrom_offset(input logic [OFS_W-1:0] idx);
        logic [COORD_W-1:0] ofs;
        unique case (idx)
            6'd0:    ofs = 32'd0;
            6'd1:    ofs = 32'd249250621;
            6'd2:    ofs = 32'd492449994;
            6'd3:    ofs = 32'd690472424;
            6'd4:    ofs = 32'd881626700;
            6'd5:    ofs = 32'd1062541960;
            6'd6:    ofs = 32'd1233657027;
            6'd7:    ofs = 32'd1392795690;
            6'd8:    ofs = 32'd1539159712;
            6'd9:    ofs = 32'd1680373143;
            6'd10:   ofs = 32'd1815907890;
            6'd11:   ofs = 32'd1950914406;
            6'd12:   ofs = 32'd2084766301;
            6'd13:   ofs = 32'd2199936179;
            6'd14:   ofs = 32'd2307285719;
            6'd15:   ofs = 32'd2409817111;
            6'd16:   ofs = 32'd2500171864;
            6'd17:   ofs = 32'd2581367074;
            6'd18:   ofs = 32'd2659444322;
            6'd19:   ofs = 32'd2718573305;
            6'd20:   ofs = 32'd2781598825;
            6'd21:   ofs = 32'd2829728720;
            6'd22:   ofs = 32'd2881033286;
            6'd23:   ofs = 32'd3036303846;
            default: ofs = '0;
        endcase
        return ofs;
    endfunction

endpackage

### hdl/gpha_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module gpha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/gpha_bin_unit.sv
// maps one genome point to an image bin: offset lookup, multiply by width, then a divide by
// the genome length through a reciprocal estimate and one correction step; uses gpha_pkg
module gpha_bin_unit import gpha_pkg::*; #(
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
    parameter int CHROM_COUNT = DEF_CHROM_COUNT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [CHROM_W-1:0]                 chrom,
    input  logic [POS_W-1:0]                   pos,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]     width,
    output logic                               busy,
    output logic [$clog2(MAX_WIDTH)-1:0]       bin
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int BW = $clog2(MAX_WIDTH);
    localparam int QW = $clog2(MAX_WIDTH) + 1;
    localparam int PW = COORD_W + WW;
    localparam int RW = WW + 1;
    localparam int EW = PW + RW;
    // floor(2^PW / genome length): the estimate is the exact quotient or one below it
    localparam logic [63:0]   RECIP_WIDE = (64'd1 << PW) / GENOME_LEN;
    localparam logic [RW-1:0] RECIP      = RW'(RECIP_WIDE);
    localparam logic [PW-1:0] DIVISOR    = PW'(GENOME_LEN);

    localparam logic [1:0] STEP_SCALE    = 2'd0;
    localparam logic [1:0] STEP_ESTIMATE = 2'd1;
    localparam logic [1:0] STEP_REMAIN   = 2'd2;
    localparam logic [1:0] STEP_FIX      = 2'd3;

    logic              busy_reg, busy_next;
    logic [1:0]        step_reg, step_next;
    logic [COORD_W-1:0] coord_reg, coord_next;
    logic [PW-1:0]     num_reg, num_next;
    logic [PW-1:0]     rem_reg, rem_next;
    logic [QW-1:0]     quo_reg, quo_next;
    logic [OFS_W-1:0]  chrom_sat;
    logic [EW-1:0]     est_wide;
    logic [PW-1:0]     back_prod;

    always_comb
    begin
        if (7'(chrom) >= 7'(CHROM_COUNT))
        begin
            chrom_sat = OFS_W'(CHROM_COUNT - 1);
        end
        else
        begin
            chrom_sat = OFS_W'(chrom);
        end
    end

    assign est_wide  = EW'(num_reg) * EW'(RECIP);
    assign back_prod = PW'(quo_reg) * DIVISOR;

    always_comb
    begin
        busy_next  = busy_reg;
        step_next  = step_reg;
        coord_next = coord_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        if (start)
        begin
            coord_next = chrom_offset(chrom_sat) + COORD_W'(pos);
            step_next  = STEP_SCALE;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            unique case (step_reg)
                STEP_SCALE:
                begin
                    num_next = PW'(coord_reg) * PW'(width);
                end
                STEP_ESTIMATE:
                begin
                    quo_next = est_wide[PW +: QW];
                end
                STEP_REMAIN:
                begin
                    rem_next = num_reg - back_prod;
                end
                STEP_FIX:
                begin
                    if (rem_reg >= DIVISOR)
                    begin
                        quo_next = quo_reg + 1'b1;
                    end
                    busy_next = 1'b0;
                end
            endcase
            step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        coord_reg <= coord_next;
        num_reg   <= num_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
    end

    // points past the genome end land in the last bin
    always_comb
    begin
        if (quo_reg >= QW'(width))
        begin
            bin = BW'(width - 1'b1);
        end
        else
        begin
            bin = BW'(quo_reg);
        end
    end

    assign busy = busy_reg;

endmodule

### hdl/genome_pair_heatmap_accumulator.sv
// top level of the genome pair heatmap accumulator: control sequencer, pixel store and
// output register; uses gpha_pkg, gpha_bin_unit and gpha_ram
//
// Plots pairs of genome points into a square 8-bit intensity image held in a single
// MAX_WIDTH*MAX_WIDTH entry ram. An add transaction maps both points to bins, raises the pixel
// at col_bin*width+row_bin by color_step (saturating at 255) and returns its new value; a read
// transaction returns the pixel at read_index and clears it (an out of range index returns zero
// and touches nothing). One transaction is in flight at a time. An add passes through the four
// steps of the bin units (scale by the width, reciprocal estimate of the divide by the genome
// length, remainder, correction), a step to latch the bins, one to form the pixel address, the
// ram read and the write-back with the result; a read goes through the ram read, then
// write-back. The next transaction is accepted once the result is registered. A finished
// result waits in the output register while the next transaction is accepted; a transaction
// that reaches write-back while that result is still stalled waits there. After reset the
// store is cleared one entry a cycle, all MAX_WIDTH*MAX_WIDTH entries (65536 by default),
// during which in_stall stays high; configuration writes are taken at any time the block is
// idle.
module genome_pair_heatmap_accumulator import gpha_pkg::*; #(
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
    parameter int CHROM_COUNT = DEF_CHROM_COUNT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 action,
    input  logic [CHROM_W-1:0]   row_chrom,
    input  logic [POS_W-1:0]     row_pos,
    input  logic [CHROM_W-1:0]   col_chrom,
    input  logic [POS_W-1:0]     col_pos,
    input  logic [IDX_W-1:0]     read_index,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [IDX_W-1:0]     pixel_index,
    output logic [PIX_W-1:0]     pixel_value
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int BW = $clog2(MAX_WIDTH);
    localparam int LW = BW + WW;
    localparam int CMPW = (WW > CFG_W) ? WW : CFG_W;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_WIDTH;
    localparam int AW = $clog2(STORE_DEPTH);
    localparam int RCW = (IDX_W > AW) ? IDX_W + 1 : AW + 1;

    gpha_state_t state_reg, state_next;

    logic [CFG_W-1:0]  image_width_reg;
    logic [STEP_W-1:0] color_step_reg;
    logic [WW-1:0]     eff_width;

    logic [AW-1:0]     clr_cnt_reg;
    logic              act_reg;
    logic              in_range_reg;
    logic [AW-1:0]     addr_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [BW-1:0]     row_bin_reg, col_bin_reg;
    logic [LW-1:0]     lin_index;

    logic              out_valid_reg;
    logic [IDX_W-1:0]  pixel_index_reg;
    logic [PIX_W-1:0]  pixel_value_reg;

    logic              in_accept;
    logic              out_free;
    logic              bin_start;
    logic              row_busy, col_busy;
    logic [BW-1:0]     row_bin, col_bin;

    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [PIX_W-1:0]  ram_wdata, ram_rdata;

    logic [PIX_W:0]    sum_wide;
    logic [PIX_W-1:0]  add_value;
    logic [PIX_W-1:0]  result_value;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg <= IMAGE_WIDTH_RST;
            color_step_reg  <= COLOR_STEP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH: image_width_reg <= cfg_data;
                REG_COLOR_STEP:  color_step_reg  <= cfg_data[STEP_W-1:0];
                default:         image_width_reg <= image_width_reg;
            endcase
        end
    end

    always_comb
    begin
        if (image_width_reg == '0)
        begin
            eff_width = WW'(1);
        end
        else if (CMPW'(image_width_reg) > CMPW'(MAX_WIDTH))
        begin
            eff_width = WW'(MAX_WIDTH);
        end
        else
        begin
            eff_width = WW'(image_width_reg);
        end
    end

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    gpha_bin_unit #(
        .MAX_WIDTH   (MAX_WIDTH),
        .CHROM_COUNT (CHROM_COUNT)
    ) u_row_bin (
        .clk   (clk),
        .rst_n (rst_n),
        .start (bin_start),
        .chrom (row_chrom),
        .pos   (row_pos),
        .width (eff_width),
        .busy  (row_busy),
        .bin   (row_bin)
    );

    gpha_bin_unit #(
        .MAX_WIDTH   (MAX_WIDTH),
        .CHROM_COUNT (CHROM_COUNT)
    ) u_col_bin (
        .clk   (clk),
        .rst_n (rst_n),
        .start (bin_start),
        .chrom (col_chrom),
        .pos   (col_pos),
        .width (eff_width),
        .busy  (col_busy),
        .bin   (col_bin)
    );

    gpha_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_pixel_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == AW'(STORE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (action == ACT_ADD) ? ST_BIN : ST_READ;
                end
            end
            ST_BIN:
            begin
                if (!row_busy && !col_busy)
                begin
                    state_next = ST_INDEX;
                end
            end
            ST_INDEX: state_next = ST_READ;
            ST_READ:  state_next = ST_WRITE;
            ST_WRITE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // saturating add of the step
    assign sum_wide  = {1'b0, ram_rdata} + {1'b0, color_step_reg};
    assign add_value = sum_wide[PIX_W] ? PIX_MAX : sum_wide[PIX_W-1:0];

    always_comb
    begin
        if (act_reg == ACT_ADD)
        begin
            result_value = add_value;
        end
        else
        begin
            result_value = in_range_reg ? ram_rdata : '0;
        end
    end

    // outputs of the sequencer
    always_comb
    begin
        in_stall  = 1'b1;
        bin_start = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = addr_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
            end
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                bin_start = in_valid && (action == ACT_ADD);
            end
            ST_READ:
            begin
                ram_re = 1'b1;
            end
            ST_WRITE:
            begin
                // a read clears the pixel, out of range reads touch nothing
                ram_we    = out_free && ((act_reg == ACT_ADD) || in_range_reg);
                ram_wdata = (act_reg == ACT_ADD) ? add_value : '0;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign lin_index = LW'(col_bin_reg) * LW'(eff_width) + LW'(row_bin_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if ((state_reg == ST_WRITE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            act_reg      <= action;
            in_range_reg <= RCW'(read_index) < RCW'(STORE_DEPTH);
            addr_reg     <= AW'(read_index);
            idx_reg      <= read_index;
        end
        if ((state_reg == ST_BIN) && !row_busy && !col_busy)
        begin
            row_bin_reg <= row_bin;
            col_bin_reg <= col_bin;
        end
        if (state_reg == ST_INDEX)
        begin
            addr_reg <= AW'(lin_index);
            idx_reg  <= IDX_W'(AW'(lin_index));
        end
        if ((state_reg == ST_WRITE) && out_free)
        begin
            pixel_index_reg <= idx_reg;
            pixel_value_reg <= result_value;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_index = pixel_index_reg;
    assign pixel_value = pixel_value_reg;

endmodule
